[src/ea2rm_pkg.sv]
// Package for the Euler angle to rotation matrix block.
// Holds the widths, fixed-point constants, CORDIC arctangent table and order codes.
// No dependencies.
package ea2rm_pkg;

    localparam int ANGLE_WIDTH     = 16;
    localparam int ENTRY_FRAC_BITS = 14;
    localparam int CORDIC_STAGES   = 16;

    localparam int ENTRY_WIDTH = ENTRY_FRAC_BITS + 2;
    localparam int INT_FRAC    = 30;
    // Angle in Q30 spans +-4.0, so 34 bits; x and y stay near 1.0.
    localparam int ZW = 34;
    localparam int XW = 33;
    localparam int QW = 32;
    localparam int PW = 64;
    localparam int ANGLE_SHIFT = INT_FRAC + 3 - ANGLE_WIDTH;
    localparam int OUT_SHIFT   = INT_FRAC - ENTRY_FRAC_BITS;

    localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [XW-1:0] Q30_GAIN    = 33'sd652032874;
    localparam logic signed [QW-1:0] Q30_ONE     = 32'sd1073741824;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_XZY = 3'd1,
        ORD_YXZ = 3'd2,
        ORD_YZX = 3'd3,
        ORD_ZXY = 3'd4,
        ORD_ZYX = 3'd5
    } t_order;

    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic [31:0] v;
        unique case (idx)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
            27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return signed'({2'b00, v});
    endfunction

endpackage

[src/ea2rm_angle_if.sv]
// Channel carrying one set of three Euler angles.
// Depends on ea2rm_pkg.
interface ea2rm_angle_if;
    logic valid;
    logic ready;
    logic signed [ea2rm_pkg::ANGLE_WIDTH-1:0] angle_x;
    logic signed [ea2rm_pkg::ANGLE_WIDTH-1:0] angle_y;
    logic signed [ea2rm_pkg::ANGLE_WIDTH-1:0] angle_z;
    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

[src/ea2rm_matrix_if.sv]
// Channel carrying the nine entries of one rotation matrix.
// Depends on ea2rm_pkg.
interface ea2rm_matrix_if;
    logic valid;
    logic ready;
    logic signed [ea2rm_pkg::ENTRY_WIDTH-1:0] m00, m01, m02;
    logic signed [ea2rm_pkg::ENTRY_WIDTH-1:0] m10, m11, m12;
    logic signed [ea2rm_pkg::ENTRY_WIDTH-1:0] m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

[src/ea2rm_cfg_if.sv]
// Write channel for the rotation order register.
// No dependencies.
interface ea2rm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/euler_angles_to_rotation_matrix_top.sv]
// Euler angles to rotation matrix: CORDIC sine/cosine and two 3x3 products.
// Depends on ea2rm_pkg, ea2rm_angle_if, ea2rm_matrix_if, ea2rm_cfg_if.
//
//   channel    | direction | payload
//   i_angle    | in        | angle_x, angle_y, angle_z (Q3.13)
//   o_matrix   | out       | m00..m22 (Q2.14, saturated)
//   i_cfg      | in        | rotation order code
//
// The pipeline takes one item per cycle while the output is not stalled.
// Its stages are angle reduction, the CORDIC stages, operand select and two
// multiply / sum-and-round pairs, then output rounding.
// Synchronous active-low reset clears the valid bits and the order register.
// When the output is stalled the whole pipeline holds; nothing is lost.
module euler_angles_to_rotation_matrix_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ea2rm_angle_if.sink           i_angle,
    ea2rm_matrix_if.source        o_matrix,
    ea2rm_cfg_if.sink             i_cfg
);
    localparam int N  = ea2rm_pkg::CORDIC_STAGES;
    localparam int XW = ea2rm_pkg::XW;
    localparam int ZW = ea2rm_pkg::ZW;
    localparam int QW = ea2rm_pkg::QW;
    localparam int PW = ea2rm_pkg::PW;
    localparam int EW = ea2rm_pkg::ENTRY_WIDTH;
    localparam int SH = ea2rm_pkg::OUT_SHIFT;
    localparam logic signed [PW-1:0] PROD_RND = PW'(64'sd1 <<< (ea2rm_pkg::INT_FRAC - 1));
    localparam logic signed [QW:0]   OUT_RND  = (QW+1)'((64'd1 << SH) >> 1);
    localparam logic signed [QW:0]   LIM      = (QW+1)'(64'd1 << ea2rm_pkg::ENTRY_FRAC_BITS);

    logic en;
    logic [2:0] r_order;

    // CORDIC pipeline, one row per axis.
    logic signed [XW-1:0] r_cx [3][N+1];
    logic signed [XW-1:0] r_cy [3][N+1];
    logic signed [ZW-1:0] r_cz [3][N+1];
    logic                 r_cf [3][N+1];
    logic                 r_cv [N+1];

    logic signed [QW-1:0] r_ma [3][3], r_mb [3][3], r_mc [3][3];
    logic signed [QW-1:0] r_mc1 [3][3], r_mc2 [3][3];
    logic signed [PW-1:0] r_p1 [3][3][3], r_p2 [3][3][3];
    logic signed [QW-1:0] r_t [3][3], r_res [3][3];
    logic signed [EW-1:0] r_m [3][3];
    logic r_vm, r_vp1, r_vt, r_vp2, r_vr, r_vo;

    logic signed [ZW-1:0] n_z [3];
    logic                 n_f [3];
    logic signed [ea2rm_pkg::ANGLE_WIDTH-1:0] ang [3];
    logic signed [QW-1:0] sn [3], cs [3];
    logic signed [QW-1:0] rot [3][3][3];
    logic signed [QW-1:0] n_ma [3][3], n_mb [3][3], n_mc [3][3];

    assign en            = !r_vo || o_matrix.ready;
    assign i_angle.ready = en;
    assign i_cfg.ready   = 1'b1;

    assign ang[0] = i_angle.angle_x;
    assign ang[1] = i_angle.angle_y;
    assign ang[2] = i_angle.angle_z;

    // Range reduction into +-pi/2; the flip bit negates sine and cosine later.
    always_comb begin
        logic signed [ZW-1:0] a;
        for (int k = 0; k < 3; k++) begin
            a = ZW'(ang[k]) <<< ea2rm_pkg::ANGLE_SHIFT;
            if (a > ea2rm_pkg::Q30_HALF_PI) begin
                n_z[k] = a - ea2rm_pkg::Q30_PI;
                n_f[k] = 1'b1;
            end else if (a < -ea2rm_pkg::Q30_HALF_PI) begin
                n_z[k] = a + ea2rm_pkg::Q30_PI;
                n_f[k] = 1'b1;
            end else begin
                n_z[k] = a;
                n_f[k] = 1'b0;
            end
        end
    end

    // Elementary rotations and operand selection by order.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sn[k] = r_cf[k][N] ? QW'(-r_cy[k][N]) : QW'(r_cy[k][N]);
            cs[k] = r_cf[k][N] ? QW'(-r_cx[k][N]) : QW'(r_cx[k][N]);
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    rot[k][r][j] = '0;
                end
            end
        end
        rot[0][0][0] = ea2rm_pkg::Q30_ONE;
        rot[0][1][1] = cs[0]; rot[0][1][2] = -sn[0];
        rot[0][2][1] = sn[0]; rot[0][2][2] = cs[0];
        rot[1][1][1] = ea2rm_pkg::Q30_ONE;
        rot[1][0][0] = cs[1]; rot[1][0][2] = sn[1];
        rot[1][2][0] = -sn[1]; rot[1][2][2] = cs[1];
        rot[2][2][2] = ea2rm_pkg::Q30_ONE;
        rot[2][0][0] = cs[2]; rot[2][0][1] = -sn[2];
        rot[2][1][0] = sn[2]; rot[2][1][1] = cs[2];
        unique case (r_order)
            ea2rm_pkg::ORD_XZY: begin n_ma = rot[0]; n_mb = rot[2]; n_mc = rot[1]; end
            ea2rm_pkg::ORD_YXZ: begin n_ma = rot[1]; n_mb = rot[0]; n_mc = rot[2]; end
            ea2rm_pkg::ORD_YZX: begin n_ma = rot[1]; n_mb = rot[2]; n_mc = rot[0]; end
            ea2rm_pkg::ORD_ZXY: begin n_ma = rot[2]; n_mb = rot[0]; n_mc = rot[1]; end
            ea2rm_pkg::ORD_ZYX: begin n_ma = rot[2]; n_mb = rot[1]; n_mc = rot[0]; end
            default:            begin n_ma = rot[0]; n_mb = rot[1]; n_mc = rot[2]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ea2rm_pkg::ORD_XYZ;
        end else if (i_cfg.valid) begin
            r_order <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= N; i++) begin
                r_cv[i] <= 1'b0;
            end
            r_vm <= 1'b0; r_vp1 <= 1'b0; r_vt <= 1'b0;
            r_vp2 <= 1'b0; r_vr <= 1'b0; r_vo <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_angle.valid;
            for (int i = 0; i < N; i++) begin
                r_cv[i+1] <= r_cv[i];
            end
            r_vm <= r_cv[N]; r_vp1 <= r_vm; r_vt <= r_vp1;
            r_vp2 <= r_vt; r_vr <= r_vp2; r_vo <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] acc;
        logic signed [QW:0]   v;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_cx[k][0] <= ea2rm_pkg::Q30_GAIN;
                r_cy[k][0] <= '0;
                r_cz[k][0] <= n_z[k];
                r_cf[k][0] <= n_f[k];
                for (int i = 0; i < N; i++) begin
                    r_cf[k][i+1] <= r_cf[k][i];
                    if (r_cz[k][i] >= 0) begin
                        r_cx[k][i+1] <= r_cx[k][i] - (r_cy[k][i] >>> i);
                        r_cy[k][i+1] <= r_cy[k][i] + (r_cx[k][i] >>> i);
                        r_cz[k][i+1] <= r_cz[k][i] - ea2rm_pkg::atan_q30(i);
                    end else begin
                        r_cx[k][i+1] <= r_cx[k][i] + (r_cy[k][i] >>> i);
                        r_cy[k][i+1] <= r_cy[k][i] - (r_cx[k][i] >>> i);
                        r_cz[k][i+1] <= r_cz[k][i] + ea2rm_pkg::atan_q30(i);
                    end
                end
            end
            r_ma <= n_ma; r_mb <= n_mb; r_mc <= n_mc;
            r_mc1 <= r_mc; r_mc2 <= r_mc1;
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_p1[r][j][k] <= PW'(r_ma[r][k]) * PW'(r_mb[k][j]);
                        r_p2[r][j][k] <= PW'(r_t[r][k]) * PW'(r_mc2[k][j]);
                    end
                    acc = r_p1[r][j][0] + r_p1[r][j][1] + r_p1[r][j][2] + PROD_RND;
                    r_t[r][j] <= QW'(acc >>> ea2rm_pkg::INT_FRAC);
                    acc = r_p2[r][j][0] + r_p2[r][j][1] + r_p2[r][j][2] + PROD_RND;
                    r_res[r][j] <= QW'(acc >>> ea2rm_pkg::INT_FRAC);
                    v = ((QW+1)'(r_res[r][j]) + OUT_RND) >>> SH;
                    if (v > LIM) begin
                        v = LIM;
                    end else if (v < -LIM) begin
                        v = -LIM;
                    end
                    r_m[r][j] <= EW'(v);
                end
            end
        end
    end

    assign o_matrix.valid = r_vo;
    assign o_matrix.m00 = r_m[0][0];
    assign o_matrix.m01 = r_m[0][1];
    assign o_matrix.m02 = r_m[0][2];
    assign o_matrix.m10 = r_m[1][0];
    assign o_matrix.m11 = r_m[1][1];
    assign o_matrix.m12 = r_m[1][2];
    assign o_matrix.m20 = r_m[2][0];
    assign o_matrix.m21 = r_m[2][1];
    assign o_matrix.m22 = r_m[2][2];

endmodule

[src/ea2rm_checker.sv]
// Port-level checks for the Euler angle to rotation matrix block.
// Depends on ea2rm_pkg; bound to euler_angles_to_rotation_matrix_top.
module ea2rm_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [ea2rm_pkg::ENTRY_WIDTH-1:0] out_m00,
    input logic signed [ea2rm_pkg::ENTRY_WIDTH-1:0] out_m11
);
    localparam int LIM = 1 << ea2rm_pkg::ENTRY_FRAC_BITS;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_m00) && $stable(out_m11))
        else $error("result changed while stalled");

    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ready |-> in_ready) else $error("input blocked with output free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (int'(out_m00) <= LIM) && (int'(out_m00) >= -LIM)
                   && (int'(out_m11) <= LIM) && (int'(out_m11) >= -LIM))
        else $error("entry beyond one");

endmodule

bind euler_angles_to_rotation_matrix_top ea2rm_checker u_ea2rm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_angle.ready),
    .out_valid (o_matrix.valid),
    .out_ready (o_matrix.ready),
    .out_m00   (o_matrix.m00),
    .out_m11   (o_matrix.m11)
);
